// File: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps
// Package for the double-ended queue: sizes, command codes and result codes.
// Used by deq_ctrl, double_ended_queue_top and the testbench; depends on nothing.
package deq_pkg;

  localparam int CAPACITY  = 1024;
  localparam int WORD_BITS = 32;

  localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W   = $clog2(CAPACITY + 1);
  localparam int SUM_W   = OCC_W + 1;
  localparam int STORE_W = (WORD_BITS < 32) ? WORD_BITS : 32;

  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_CLEAR      = 3'd6
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_WORD  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [OCC_W-1:0]   occ_t;
  typedef logic [STORE_W-1:0] word_t;

endpackage

// File: rtl/core/double_ended_queue_top.sv
`timescale 1ns / 1ps
// Top level of the double-ended queue: the ring memory and its control.
// Depends on deq_pkg, deq_ram and deq_ctrl.
//
// The queue holds up to 1024 words in a single-port ring memory and takes one
// command per cycle while in_stall is low; each command gives exactly one result
// item after it is accepted: the memory read is registered in the read-pending
// stage and the result then passes through an output register. Each command makes
// at most one memory access, so the memory port sets the rate of one item per
// cycle when the output does not stall. A further item is accepted while a
// finished result waits to be taken. The memory holds no reset state and needs no
// clearing pass; clear only resets the front position and the occupancy.
module double_ended_queue_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [deq_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [deq_pkg::FIELD_W-1:0]  in_push_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [deq_pkg::STATUS_W-1:0] out_status,
  output logic [deq_pkg::FIELD_W-1:0]  out_read_word
);
  import deq_pkg::*;

  logic  mem_we;
  logic  mem_re;
  addr_t mem_addr;
  word_t mem_wdata;
  word_t mem_rdata;

  deq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_push_word (in_push_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_read_word(out_read_word),
    .mem_we       (mem_we),
    .mem_re       (mem_re),
    .mem_addr     (mem_addr),
    .mem_wdata    (mem_wdata),
    .mem_rdata    (mem_rdata)
  );

  deq_ram #(
    .DEPTH (CAPACITY),
    .DATA_W(STORE_W),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

endmodule

// File: rtl/core/deq_ram.sv
`timescale 1ns / 1ps
// Single-port synchronous RAM with a registered read, one access per cycle.
// Generic; depends on nothing.
module deq_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 32,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/deq_ctrl.sv
`timescale 1ns / 1ps
// Queue control: front and occupancy registers, ring address generation,
// a read-pending stage and the output register. Depends on deq_pkg.
module deq_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [deq_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic [deq_pkg::FIELD_W-1:0]      in_push_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [deq_pkg::STATUS_W-1:0]     out_status,
  output logic [deq_pkg::FIELD_W-1:0]      out_read_word,
  output logic                             mem_we,
  output logic                             mem_re,
  output deq_pkg::addr_t                   mem_addr,
  output deq_pkg::word_t                   mem_wdata,
  input  deq_pkg::word_t                   mem_rdata
);
  import deq_pkg::*;

  localparam logic [SUM_W-1:0] CAP_S  = SUM_W'(CAPACITY);
  localparam addr_t            LAST_A = ADDR_W'(CAPACITY - 1);
  localparam occ_t             CAP_O  = OCC_W'(CAPACITY);

  addr_t   front_r, front_nxt;
  occ_t    occ_r, occ_nxt;
  logic    s1_valid_r;
  status_t s1_status_r;
  logic    s1_word_r;
  logic    out_valid_r;
  status_t out_status_r;
  logic [FIELD_W-1:0] out_word_r;

  status_t cmd_status;
  logic    accept;
  logic    out_load;
  logic    s1_free;
  logic [SUM_W-1:0] sum_back;
  logic [SUM_W-1:0] sum_last;
  addr_t   back_push_a;
  addr_t   back_last_a;
  addr_t   front_dec_a;
  addr_t   front_inc_a;
  logic [FIELD_W-1:0] word_ext;

  assign out_load = !out_valid_r || !out_stall;
  assign s1_free  = !s1_valid_r || out_load;
  assign in_stall = !s1_free;
  assign accept   = in_valid && s1_free;

  always_comb begin
    sum_back    = SUM_W'(front_r) + SUM_W'(occ_r);
    sum_last    = sum_back - SUM_W'(1);
    back_push_a = (sum_back >= CAP_S) ? ADDR_W'(sum_back - CAP_S) : ADDR_W'(sum_back);
    back_last_a = (sum_last >= CAP_S) ? ADDR_W'(sum_last - CAP_S) : ADDR_W'(sum_last);
    front_dec_a = (front_r == '0) ? LAST_A : front_r - ADDR_W'(1);
    front_inc_a = (front_r == LAST_A) ? '0 : front_r + ADDR_W'(1);
  end

  always_comb begin
    front_nxt  = front_r;
    occ_nxt    = occ_r;
    cmd_status = ST_OK;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = front_r;
    mem_wdata  = in_push_word[STORE_W-1:0];
    unique case (opcode_t'(in_opcode))
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (occ_r == CAP_O) begin
          cmd_status = ST_FULL;
        end else begin
          mem_we  = accept;
          occ_nxt = occ_r + OCC_W'(1);
          if (opcode_t'(in_opcode) == OP_PUSH_FRONT) begin
            mem_addr  = front_dec_a;
            front_nxt = front_dec_a;
          end else begin
            mem_addr = back_push_a;
          end
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (occ_r == '0) begin
          cmd_status = ST_EMPTY;
        end else begin
          cmd_status = ST_WORD;
          mem_re     = accept;
          mem_addr   = front_r;
          if (opcode_t'(in_opcode) == OP_POP_FRONT) begin
            front_nxt = front_inc_a;
            occ_nxt   = occ_r - OCC_W'(1);
          end
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        if (occ_r == '0) begin
          cmd_status = ST_EMPTY;
        end else begin
          cmd_status = ST_WORD;
          mem_re     = accept;
          mem_addr   = back_last_a;
          if (opcode_t'(in_opcode) == OP_POP_BACK) begin
            occ_nxt = occ_r - OCC_W'(1);
          end
        end
      end
      OP_CLEAR: begin
        front_nxt = '0;
        occ_nxt   = '0;
      end
      default: begin
        cmd_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    word_ext = '0;
    word_ext[STORE_W-1:0] = mem_rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      occ_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        front_r <= front_nxt;
        occ_r   <= occ_nxt;
      end
      if (s1_free) begin
        s1_valid_r <= accept;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_status_r <= cmd_status;
      s1_word_r   <= mem_re;
    end
    if (out_load) begin
      out_status_r <= s1_status_r;
      out_word_r   <= s1_word_r ? word_ext : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_word = out_word_r;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue_top: drives command items with
// random gaps and output stalls and checks every result against its own queue model.
// Depends on deq_pkg and the RTL of double_ended_queue_top.
module tb;
  import deq_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

  typedef struct {
    status_t             status;
    logic [FIELD_W-1:0]  word;
  } answer_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [OPCODE_W-1:0] in_opcode;
  logic [FIELD_W-1:0]  in_push_word;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [FIELD_W-1:0]  out_read_word;

  word_t   model_ring [CAPACITY];
  int      model_front;
  int      model_count;
  answer_t answer_q [$];
  answer_t exp_answer;
  int      mismatch_count = 0;
  bit      steady = 1'b0;

  double_ended_queue_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_push_word (in_push_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_read_word(out_read_word)
  );

  always #5 clk = ~clk;

  function automatic answer_t predict_answer(input logic [OPCODE_W-1:0] op,
                                             input logic [FIELD_W-1:0] word);
    answer_t a;
    int      pos;
    a.status = ST_OK;
    a.word   = '0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (model_count >= CAPACITY) begin
          a.status = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          model_front = (model_front + CAPACITY - 1) % CAPACITY;
          model_ring[model_front] = word[STORE_W-1:0];
          model_count++;
        end else begin
          pos = (model_front + model_count) % CAPACITY;
          model_ring[pos] = word[STORE_W-1:0];
          model_count++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (model_count == 0) begin
          a.status = ST_EMPTY;
        end else begin
          if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) begin
            pos = model_front;
          end else begin
            pos = (model_front + model_count - 1) % CAPACITY;
          end
          a.word[STORE_W-1:0] = model_ring[pos];
          a.status = ST_WORD;
          if (op == OP_POP_FRONT) begin
            model_front = (model_front + 1) % CAPACITY;
            model_count--;
          end else if (op == OP_POP_BACK) begin
            model_count--;
          end
        end
      end
      OP_CLEAR: begin
        model_front = 0;
        model_count = 0;
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 19);
    if (steady || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic issue_command(input logic [OPCODE_W-1:0] op, input logic [FIELD_W-1:0] word);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_opcode    = op;
    in_push_word = word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    answer_q.push_back(predict_answer(op, word));
    @(negedge clk);
  endtask

  task automatic wait_for_answers();
    in_valid = 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_empty_and_basic();
    issue_command(OP_POP_FRONT, 32'hFFFF_FFFF);
    issue_command(OP_POP_BACK, 32'h0000_0000);
    issue_command(OP_PEEK_FRONT, 32'h1234_5678);
    issue_command(OP_PEEK_BACK, 32'hFFFF_FFFF);
    issue_command(OP_UNUSED, 32'hFFFF_FFFF);
    issue_command(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    issue_command(OP_PUSH_BACK, 32'h0000_0000);
    issue_command(OP_PUSH_FRONT, 32'hA5A5_A5A5);
    issue_command(OP_PUSH_BACK, 32'h5A5A_5A5A);
    issue_command(OP_UNUSED, 32'h0000_0000);
    issue_command(OP_PEEK_FRONT, 32'h0000_0000);
    issue_command(OP_PEEK_BACK, 32'hFFFF_FFFF);
    issue_command(OP_POP_FRONT, 32'h0000_0000);
    issue_command(OP_POP_BACK, 32'hFFFF_FFFF);
    issue_command(OP_POP_BACK, 32'h0000_0000);
    issue_command(OP_POP_FRONT, 32'hFFFF_FFFF);
    issue_command(OP_POP_FRONT, 32'h0000_0000);
    issue_command(OP_PUSH_BACK, 32'h0000_0001);
    issue_command(OP_CLEAR, 32'hFFFF_FFFF);
    issue_command(OP_PEEK_FRONT, 32'h0000_0000);
    issue_command(OP_PEEK_BACK, 32'h0000_0000);
    wait_for_answers();
  endtask

  task automatic test_full_ring();
    int i;
    issue_command(OP_CLEAR, $urandom);
    for (i = 0; i < CAPACITY; i++) begin
      issue_command($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom);
    end
    issue_command(OP_PUSH_FRONT, $urandom);
    issue_command(OP_PUSH_BACK, $urandom);
    issue_command(OP_PEEK_FRONT, $urandom);
    issue_command(OP_PEEK_BACK, $urandom);
    issue_command(OP_POP_FRONT, $urandom);
    issue_command(OP_PUSH_BACK, $urandom);
    issue_command(OP_PUSH_FRONT, $urandom);
    issue_command(OP_POP_BACK, $urandom);
    issue_command(OP_PUSH_FRONT, $urandom);
    issue_command(OP_PUSH_BACK, $urandom);
    issue_command(OP_POP_FRONT, $urandom);
    issue_command(OP_POP_BACK, $urandom);
    issue_command(OP_CLEAR, $urandom);
    issue_command(OP_POP_BACK, $urandom);
    wait_for_answers();
  endtask

  task automatic test_random_traffic(input int count, input int push_pct, input bit no_idle);
    int                  i;
    int                  r;
    logic [OPCODE_W-1:0] op;
    steady = no_idle;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else if (r >= 97) begin
        op = OP_UNUSED;
      end else if (r >= 95) begin
        op = OP_CLEAR;
      end else begin
        op = OPCODE_W'($urandom_range(int'(OP_POP_FRONT), int'(OP_PEEK_BACK)));
      end
      issue_command(op, $urandom);
    end
    wait_for_answers();
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual status %0d word %h",
                 $time, out_status, out_read_word);
      end else begin
        exp_answer = answer_q.pop_front();
        if (out_status !== exp_answer.status) begin
          mismatch_count++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, exp_answer.status, out_status);
        end
        if (out_read_word !== exp_answer.word) begin
          mismatch_count++;
          $display("%0t: read_word mismatch, expected %h, actual %h",
                   $time, exp_answer.word, out_read_word);
        end
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (steady || !rst_n) begin
        out_stall  = 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if ($urandom_range(0, 5) == 0) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_opcode    = '0;
    in_push_word = '0;
    model_front  = 0;
    model_count  = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_empty_and_basic();
    test_full_ring();
    test_random_traffic(20, 55, 1'b0);
    test_random_traffic(20, 70, 1'b0);
    test_random_traffic(20, 30, 1'b1);
    test_random_traffic(20, 50, 1'b0);

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && answer_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/deq_ctrl.sv
rtl/core/double_ended_queue_top.sv
tb/tb.sv
